// ===== hw/rtl/bounded_substring_search_top_defines.svh =====
// Assertion helpers shared by the search block.
// Each check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef BOUNDED_SUBSTRING_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_SUBSTRING_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("search block check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("search block check failed in the next cycle");

`endif

// ===== hw/rtl/bss_pkg.sv =====
package bss_pkg;

  // Fixed field widths.
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_REG_W  = 5;

  // The pattern registers hold this many bytes, whatever the cell count.
  localparam int PAT_BYTES  = 16;
  localparam int PAT_IDX_W  = 4;

  // Defaults for the top-level parameters.
  localparam int             DEF_MAX_PATTERN  = 16;
  localparam longint unsigned DEF_MAX_HAYSTACK = 64'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  // Per-cell compare setup: whether the cell takes part, and the byte it expects.
  typedef struct packed {
    logic              used;
    logic [BYTE_W-1:0] pat;
  } cell_cfg_t;

endpackage

// ===== hw/rtl/bss_cell.sv =====
module bss_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [bss_pkg::BYTE_W-1:0] byte_in,
  input  bss_pkg::cell_cfg_t        cfg,
  output logic [bss_pkg::BYTE_W-1:0] byte_out,
  output logic                      match
);

  logic [bss_pkg::BYTE_W-1:0] byte_r;

  // Take the neighbor's byte whenever shift_en is high.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // The byte arriving from the neighbor is this cell's window byte after the shift.
  assign match = !cfg.used || (byte_in == cfg.pat);

endmodule

// ===== hw/rtl/bounded_substring_search_top.sv =====
// Bounded substring search. Bytes of a haystack enter one per cycle on the in_ channel, and
// the block reports the start offset of the first occurrence of the configured 1 to 16 byte
// pattern, or found = 0 at the marked last byte when there was none. A new byte is taken
// every cycle; its result, if any, appears on the out_ channel in the cycle after the byte is
// taken, held in an output register. The input stalls only while a result waits in that
// register and the out_ side stalls it, so with no output stall bytes follow back to back.
// That rate is set by the row of window cells: each cell holds one recent byte, passes it
// to its neighbor on each byte until a match in the haystack, and compares in parallel, so
// the whole match decision is one level of registers deep. The pattern registers must be
// written only while no result is pending.
`include "bounded_substring_search_top_defines.svh"

module bounded_substring_search_top #(
  parameter int              MAX_PATTERN  = bss_pkg::DEF_MAX_PATTERN,
  parameter longint unsigned MAX_HAYSTACK = bss_pkg::DEF_MAX_HAYSTACK
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bss_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_last_byte,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic [bss_pkg::POS_W-1:0]     out_match_position,
  output logic                          out_overflow,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_HAYSTACK + 64'd1);
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  // Configuration registers.
  logic [bss_pkg::CFG_DATA_W-1:0] pattern_low_r;
  logic [bss_pkg::CFG_DATA_W-1:0] pattern_high_r;
  logic [bss_pkg::LEN_REG_W-1:0]  pattern_length_r;

  // Search state.
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             ovf_r, ovf_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [bss_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic [LEN_W-1:0]          eff_len;
  logic [7:0]                pat_bytes [bss_pkg::PAT_BYTES];
  bss_pkg::cell_cfg_t        cell_cfg [MAX_PATTERN];
  logic [bss_pkg::BYTE_W-1:0] chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]    match_vec;

  logic             accept;
  logic             process;
  logic             sat;
  logic [CNT_W-1:0] cnt_new;
  logic             ovf_new;
  logic             hit;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= bss_pkg::LEN_REG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bss_pkg::REG_PATTERN_LOW:    pattern_low_r    <= cfg_data;
        bss_pkg::REG_PATTERN_HIGH:   pattern_high_r   <= cfg_data;
        bss_pkg::REG_PATTERN_LENGTH: pattern_length_r <= cfg_data[bss_pkg::LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configured length to the range the cell row can handle.
  always_comb begin
    priority if (pattern_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length_r > bss_pkg::LEN_REG_W'(MAX_PATTERN)) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(pattern_length_r);
    end
  end

  // Split the pattern registers into bytes.
  always_comb begin
    for (int j = 0; j < bss_pkg::PAT_BYTES; j++) begin
      if (j < 8) begin
        pat_bytes[j] = pattern_low_r[8*j +: 8];
      end else begin
        pat_bytes[j] = pattern_high_r[8*(j-8) +: 8];
      end
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign process  = accept && !done_r;

  // Row of window cells; the newest byte enters cell 0.
  assign chain[0] = in_data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [bss_pkg::LEN_REG_W-1:0] idx;

    // Cell k holds the byte that must equal pattern byte (length - 1 - k).
    assign idx              = bss_pkg::LEN_REG_W'(eff_len) - bss_pkg::LEN_REG_W'(k)
                              - bss_pkg::LEN_REG_W'(1);
    assign cell_cfg[k].used = bss_pkg::LEN_REG_W'(k) < bss_pkg::LEN_REG_W'(eff_len);
    assign cell_cfg[k].pat  = pat_bytes[idx[bss_pkg::PAT_IDX_W-1:0]];

    if (k < MAX_PATTERN - 1) begin : g_link
      bss_cell u_cell (
        .clk      (clk),
        .shift_en (process),
        .byte_in  (chain[k]),
        .cfg      (cell_cfg[k]),
        .byte_out (chain[k+1]),
        .match    (match_vec[k])
      );
    end else begin : g_end
      bss_cell u_cell (
        .clk      (clk),
        .shift_en (process),
        .byte_in  (chain[k]),
        .cfg      (cell_cfg[k]),
        .byte_out (),
        .match    (match_vec[k])
      );
    end
  end

  // Byte count saturates at the haystack limit and flags the overflow.
  assign sat     = cnt_r >= CNT_W'(MAX_HAYSTACK);
  assign cnt_new = sat ? cnt_r : cnt_r + CNT_W'(1);
  assign ovf_new = ovf_r || sat;

  // A hit needs every used cell to agree and enough bytes seen for a full pattern.
  assign hit = process && (&match_vec) && (cnt_new >= CNT_W'(eff_len));

  // Next search state and result.
  always_comb begin
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;

    if (process) begin
      cnt_nxt = cnt_new;
      ovf_nxt = ovf_new;
      if (hit) begin
        done_nxt      = 1'b1;
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_pos_nxt   = bss_pkg::POS_W'(cnt_new) - bss_pkg::POS_W'(eff_len);
        out_ovf_nxt   = ovf_new;
      end else if (in_last_byte) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b0;
        out_pos_nxt   = '0;
        out_ovf_nxt   = ovf_new;
      end
    end

    // The last byte ends the haystack and clears the search.
    if (accept && in_last_byte) begin
      cnt_nxt  = '0;
      done_nxt = 1'b0;
      ovf_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      done_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;
  assign out_overflow       = out_ovf_r;

  // A new result only ever follows an accepted byte.
  `BSS_ASSERT_NOW(a_result_after_byte, $rose(out_valid_r), $past(in_valid && !in_stall))
  // A last byte leaves the search state cleared.
  `BSS_ASSERT_NEXT(a_last_clears, accept && in_last_byte, cnt_r == '0 && !done_r && !ovf_r)
  // A reported match means at least one byte was counted.
  `BSS_ASSERT_NOW(a_done_has_count, done_r, cnt_r != '0)
  // The overflow flag is only set once the count has reached its limit.
  `BSS_ASSERT_NOW(a_ovf_saturated, ovf_r, cnt_r == CNT_W'(MAX_HAYSTACK))
  // A no-match result carries a zero position.
  `BSS_ASSERT_NOW(a_miss_zero_pos, out_valid_r && !out_found_r, out_pos_r == '0)

endmodule
